/* design/etcs_pkg.sv */
// Shared types and constants for the elapsed time counter.
package etcs_pkg;

    localparam logic [9:0] MAX_HOURS = 10'd999;
    localparam logic [5:0] LAST_UNIT = 6'd59;

    typedef enum logic [1:0] {
        RUN_STOPPED = 2'd0,
        RUN_RUNNING = 2'd1,
        RUN_MAXED   = 2'd2
    } etcs_run_t;

    typedef enum logic [3:0] {
        MODE_TICK    = 4'd0,
        MODE_CLEAR   = 4'd1,
        MODE_START   = 4'd2,
        MODE_STOP    = 4'd3,
        MODE_SET_MAX = 4'd4,
        MODE_ADD_MIN = 4'd5,
        MODE_ADD_HRS = 4'd6,
        MODE_SUB_MIN = 4'd7,
        MODE_SUB_HRS = 4'd8
    } etcs_mode_t;

    typedef struct packed {
        logic [9:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [5:0] frames;
    } etcs_count_t;

    typedef struct packed {
        etcs_run_t   run;
        etcs_count_t count;
    } etcs_state_t;

    localparam etcs_state_t MAX_STATE = '{
        run:   RUN_MAXED,
        count: '{hours: MAX_HOURS, minutes: LAST_UNIT, seconds: LAST_UNIT, frames: LAST_UNIT}
    };

    localparam etcs_state_t CLEAR_STATE = '{
        run:   RUN_STOPPED,
        count: '{hours: 10'd0, minutes: 6'd0, seconds: 6'd0, frames: 6'd0}
    };

endpackage

/* design/etcs_tick.sv */
// One frame advance with cascaded carries and saturation at the ceiling.
module etcs_tick
(
    input  etcs_pkg::etcs_state_t cur,
    output etcs_pkg::etcs_state_t nxt
);

    always_comb
    begin
        nxt = cur;
        if (cur.run == etcs_pkg::RUN_RUNNING)
        begin
            if (cur.count.frames != etcs_pkg::LAST_UNIT)
            begin
                nxt.count.frames = cur.count.frames + 6'd1;
            end
            else
            begin
                nxt.count.frames = 6'd0;
                if (cur.count.seconds != etcs_pkg::LAST_UNIT)
                begin
                    nxt.count.seconds = cur.count.seconds + 6'd1;
                end
                else
                begin
                    nxt.count.seconds = 6'd0;
                    if (cur.count.minutes != etcs_pkg::LAST_UNIT)
                    begin
                        nxt.count.minutes = cur.count.minutes + 6'd1;
                    end
                    else if (cur.count.hours != etcs_pkg::MAX_HOURS)
                    begin
                        nxt.count.minutes = 6'd0;
                        nxt.count.hours   = cur.count.hours + 10'd1;
                    end
                    else
                    begin
                        // carry out of the top hour: pin at the ceiling
                        nxt = etcs_pkg::MAX_STATE;
                    end
                end
            end
        end
    end

endmodule

/* design/etcs_cmd.sv */
// Command decode and next-state logic, including the follow-up tick.
module etcs_cmd
(
    input  etcs_pkg::etcs_state_t cur,
    input  logic [3:0]            mode,
    input  logic [14:0]           amount,
    output etcs_pkg::etcs_state_t nxt
);

    // x / 60 as (x * ceil(2^21 / 60)) >> 21, exact for x below 74898
    localparam logic [16:0] DIV60_MUL   = 17'd34953;
    localparam int          DIV60_SHIFT = 21;

    logic [15:0]           amount_ext;
    logic [15:0]           min_total;
    logic [15:0]           tot_min;
    logic [15:0]           tot_diff;
    logic                  sub_min_under;
    logic [15:0]           div_in;
    logic [32:0]           div_prod;
    logic [10:0]           div_q;
    logic [15:0]           div_rem;
    logic [10:0]           add_min_hours;
    logic [15:0]           add_hrs_sum;
    logic                  sub_hrs_under;
    logic                  do_tick;
    etcs_pkg::etcs_state_t pre;
    etcs_pkg::etcs_state_t ticked;

    assign amount_ext = {1'b0, amount};
    assign min_total  = {10'd0, cur.count.minutes} + amount_ext;

    // hours * 60 + minutes as shift and subtract
    assign tot_min = {cur.count.hours, 6'd0} - {4'd0, cur.count.hours, 2'd0}
                   + {10'd0, cur.count.minutes};
    assign sub_min_under = tot_min < amount_ext;
    assign tot_diff      = tot_min - amount_ext;

    // share one reciprocal multiplier between the two minute commands
    assign div_in   = (mode == etcs_pkg::MODE_SUB_MIN) ? tot_diff : min_total;
    assign div_prod = {17'd0, div_in} * {16'd0, DIV60_MUL};
    assign div_q    = div_prod[DIV60_SHIFT +: 11];
    assign div_rem  = div_in - ({div_q[9:0], 6'd0} - {4'd0, div_q[9:0], 2'd0});

    assign add_min_hours = {1'b0, cur.count.hours} + div_q;
    assign add_hrs_sum   = {6'd0, cur.count.hours} + amount_ext;
    assign sub_hrs_under = {6'd0, cur.count.hours} < amount_ext;

    always_comb
    begin
        pre     = cur;
        do_tick = 1'b0;
        case (mode)
            etcs_pkg::MODE_TICK:
            begin
                do_tick = 1'b1;
            end
            etcs_pkg::MODE_CLEAR:
            begin
                pre = etcs_pkg::CLEAR_STATE;
            end
            etcs_pkg::MODE_START:
            begin
                pre.run = etcs_pkg::RUN_RUNNING;
            end
            etcs_pkg::MODE_STOP:
            begin
                pre.run = etcs_pkg::RUN_STOPPED;
            end
            etcs_pkg::MODE_SET_MAX:
            begin
                pre = etcs_pkg::MAX_STATE;
            end
            etcs_pkg::MODE_ADD_MIN:
            begin
                do_tick = 1'b1;
                if (add_min_hours > {1'b0, etcs_pkg::MAX_HOURS})
                begin
                    pre = etcs_pkg::MAX_STATE;
                end
                else
                begin
                    pre.count.hours   = add_min_hours[9:0];
                    pre.count.minutes = div_rem[5:0];
                end
            end
            etcs_pkg::MODE_ADD_HRS:
            begin
                do_tick = 1'b1;
                if (add_hrs_sum > {6'd0, etcs_pkg::MAX_HOURS})
                begin
                    pre = etcs_pkg::MAX_STATE;
                end
                else
                begin
                    pre.count.hours = add_hrs_sum[9:0];
                end
            end
            etcs_pkg::MODE_SUB_MIN:
            begin
                do_tick = 1'b1;
                if (sub_min_under)
                begin
                    pre     = etcs_pkg::CLEAR_STATE;
                    pre.run = etcs_pkg::RUN_RUNNING;
                end
                else
                begin
                    pre.count.hours   = div_q[9:0];
                    pre.count.minutes = div_rem[5:0];
                end
            end
            etcs_pkg::MODE_SUB_HRS:
            begin
                if (sub_hrs_under)
                begin
                    pre     = etcs_pkg::CLEAR_STATE;
                    pre.run = etcs_pkg::RUN_RUNNING;
                end
                else
                begin
                    do_tick         = 1'b1;
                    pre.count.hours = cur.count.hours - amount[9:0];
                end
            end
            default:
            begin
                pre = cur;
            end
        endcase
    end

    etcs_tick u_tick
    (
        .cur (pre),
        .nxt (ticked)
    );

    assign nxt = do_tick ? ticked : pre;

endmodule

/* design/elapsed_time_counter_saturating_unit.sv */
// An accepted word waits in the command register until the result slot is free
// or draining, then its result goes to the counter register. Throughput: one word
// per cycle while out_stall is low; the whole command, including the follow-up
// tick, resolves between the command register and the counter register. While
// out_stall holds a result, the command register still takes one more word.
// Reset: counter clears to 000:00:00:00, stopped, and both stages empty.
module elapsed_time_counter_saturating_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  mode,
    input  logic [14:0] amount,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [9:0]  hours,
    output logic [5:0]  minutes,
    output logic [5:0]  seconds,
    output logic [5:0]  frames,
    output logic [1:0]  run_state
);

    // command register: holds one accepted word until the counter takes it
    logic        cmd_valid_reg;
    logic        cmd_valid_next;
    logic [3:0]  cmd_mode_reg;
    logic [14:0] cmd_amount_reg;

    // counter register doubles as the result register: it only changes
    // when a new result is produced, so it always shows the latest one
    etcs_pkg::etcs_state_t state_reg;
    etcs_pkg::etcs_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    logic in_accept;
    logic advance;

    // advance a command when the result slot is empty or being drained
    assign advance   = cmd_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = cmd_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (in_accept)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (advance)
        begin
            cmd_valid_next = 1'b0;
        end
    end

    assign out_valid_next = advance || (out_valid_reg && out_stall);

    etcs_cmd u_cmd
    (
        .cur    (state_reg),
        .mode   (cmd_mode_reg),
        .amount (cmd_amount_reg),
        .nxt    (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= etcs_pkg::CLEAR_STATE;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            out_valid_reg <= out_valid_next;
            // hold the counter unless a command resolves this cycle
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload of the command register needs no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_mode_reg   <= mode;
            cmd_amount_reg <= amount;
        end
    end

    assign out_valid = out_valid_reg;
    assign hours     = state_reg.count.hours;
    assign minutes   = state_reg.count.minutes;
    assign seconds   = state_reg.count.seconds;
    assign frames    = state_reg.count.frames;
    assign run_state = state_reg.run;

endmodule

/* tb/sv/elapsed_time_counter_saturating_unit_tb.sv */
// Self-checking testbench for the saturating elapsed time counter.
module elapsed_time_counter_saturating_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD       = 10;
    localparam int          RESET_CYCLES     = 10;
    localparam int          STUCK_LIMIT      = 1000;
    localparam int          SETTLE_CYCLES    = 10;
    localparam int          MAX_SHOWN        = 10;
    localparam int          MAX_IDLE         = 14;
    localparam int          LONG_HOLD        = 60;
    localparam int          UNITS_PER_STEP   = 60;
    localparam logic [14:0] AMOUNT_MAX       = 15'h7FFF;
    // Codes past the last real command: the block must report and change nothing.
    localparam logic [3:0]  MODE_SPARE_FIRST = 4'd9;
    localparam logic [3:0]  MODE_SPARE_LAST  = 4'd15;

    // Drive every block input to a known value from time zero.
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [3:0]  mode      = etcs_pkg::MODE_TICK;
    logic [14:0] amount    = '0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [9:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [5:0]  frames;
    logic [1:0]  run_state;

    // Predicted clock; the ints leave headroom to spot a carry past hour 999.
    int                  now_hours;
    int                  now_minutes;
    int                  now_seconds;
    int                  now_frames;
    etcs_pkg::etcs_run_t now_run;

    // Readings the block still owes, oldest first.
    etcs_pkg::etcs_state_t pending_readings[$];

    int          error_count        = 0;
    int          words_sent         = 0;
    int          results_checked    = 0;
    int          max_entries        = 0;
    int          underflow_restarts = 0;
    // Drop all idling on both sides while set.
    bit          steady_flow        = 1'b0;
    // Ask the output side for one long stall of this many cycles.
    int          hold_request       = 0;

    elapsed_time_counter_saturating_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .amount    (amount),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hours     (hours),
        .minutes   (minutes),
        .seconds   (seconds),
        .frames    (frames),
        .run_state (run_state)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Clock predictor
    // ------------------------------------------------------------------

    function automatic void clear_clock();
        now_hours   = 0;
        now_minutes = 0;
        now_seconds = 0;
        now_frames  = 0;
        now_run     = etcs_pkg::RUN_STOPPED;
    endfunction

    function automatic void saturate_clock();
        now_hours   = int'(etcs_pkg::MAX_HOURS);
        now_minutes = int'(etcs_pkg::LAST_UNIT);
        now_seconds = int'(etcs_pkg::LAST_UNIT);
        now_frames  = int'(etcs_pkg::LAST_UNIT);
        now_run     = etcs_pkg::RUN_MAXED;
        max_entries++;
    endfunction

    // Advance one frame, carrying up the chain; only a running clock moves.
    function automatic void advance_frame();
        if (now_run != etcs_pkg::RUN_RUNNING)
            return;
        now_frames++;
        if (now_frames < UNITS_PER_STEP)
            return;
        now_frames = 0;
        now_seconds++;
        if (now_seconds < UNITS_PER_STEP)
            return;
        now_seconds = 0;
        now_minutes++;
        if (now_minutes < UNITS_PER_STEP)
            return;
        now_minutes = 0;
        now_hours++;
        if (now_hours > int'(etcs_pkg::MAX_HOURS))
            saturate_clock();
    endfunction

    // Apply one accepted command and queue the reading it must produce.
    function automatic void apply_command(input logic [3:0] cmd, input logic [14:0] amt);
        int                    total;
        etcs_pkg::etcs_state_t reading;
        case (cmd)
            etcs_pkg::MODE_TICK:
                advance_frame();
            etcs_pkg::MODE_CLEAR:
                clear_clock();
            etcs_pkg::MODE_START:
                now_run = etcs_pkg::RUN_RUNNING;
            etcs_pkg::MODE_STOP:
                now_run = etcs_pkg::RUN_STOPPED;
            etcs_pkg::MODE_SET_MAX:
                saturate_clock();
            etcs_pkg::MODE_ADD_MIN:
            begin
                total = now_minutes + int'(amt);
                if (now_hours + total / UNITS_PER_STEP > int'(etcs_pkg::MAX_HOURS))
                    saturate_clock();
                else
                begin
                    now_hours   = now_hours + total / UNITS_PER_STEP;
                    now_minutes = total % UNITS_PER_STEP;
                end
                advance_frame();
            end
            etcs_pkg::MODE_ADD_HRS:
            begin
                if (now_hours + int'(amt) > int'(etcs_pkg::MAX_HOURS))
                    saturate_clock();
                else
                    now_hours = now_hours + int'(amt);
                advance_frame();
            end
            etcs_pkg::MODE_SUB_MIN:
            begin
                // Borrow exactly across hours; seconds and frames stay put.
                total = now_hours * UNITS_PER_STEP + now_minutes;
                if (total < int'(amt))
                begin
                    clear_clock();
                    now_run = etcs_pkg::RUN_RUNNING;
                    underflow_restarts++;
                end
                else
                begin
                    total       = total - int'(amt);
                    now_hours   = total / UNITS_PER_STEP;
                    now_minutes = total % UNITS_PER_STEP;
                end
                advance_frame();
            end
            etcs_pkg::MODE_SUB_HRS:
            begin
                // Going below zero restarts from zero with no follow-up tick.
                if (now_hours < int'(amt))
                begin
                    clear_clock();
                    now_run = etcs_pkg::RUN_RUNNING;
                    underflow_restarts++;
                end
                else
                begin
                    now_hours = now_hours - int'(amt);
                    advance_frame();
                end
            end
            default:
                ;
        endcase
        reading.run           = now_run;
        reading.count.hours   = now_hours[9:0];
        reading.count.minutes = now_minutes[5:0];
        reading.count.seconds = now_seconds[5:0];
        reading.count.frames  = now_frames[5:0];
        pending_readings.push_back(reading);
    endfunction

    function automatic void log_error(input string what);
        error_count++;
        if (error_count <= MAX_SHOWN)
            $display("ERROR at %0t: %s", $time, what);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [3:0] draw_mode();
        int r;
        r = $urandom_range(99, 0);
        if (r < 30)
            return etcs_pkg::MODE_TICK;
        if (r < 36)
            return etcs_pkg::MODE_CLEAR;
        if (r < 46)
            return etcs_pkg::MODE_START;
        if (r < 51)
            return etcs_pkg::MODE_STOP;
        if (r < 55)
            return etcs_pkg::MODE_SET_MAX;
        if (r < 64)
            return etcs_pkg::MODE_ADD_MIN;
        if (r < 72)
            return etcs_pkg::MODE_ADD_HRS;
        if (r < 82)
            return etcs_pkg::MODE_SUB_MIN;
        if (r < 92)
            return etcs_pkg::MODE_SUB_HRS;
        return 4'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
    endfunction

    // Mix small amounts, hour-sized ones, the full range and the top edge.
    function automatic logic [14:0] draw_amount();
        case ($urandom_range(3, 0))
            0:       return 15'($urandom_range(90, 0));
            1:       return 15'($urandom_range(int'(etcs_pkg::MAX_HOURS), 0));
            2:       return 15'($urandom_range(int'(AMOUNT_MAX), 0));
            default: return AMOUNT_MAX - 15'($urandom_range(60, 0));
        endcase
    endfunction

    // Offer one word after a random gap, hold it until taken, then predict.
    task automatic send_word(input logic [3:0] cmd, input logic [14:0] amt);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(MAX_IDLE, 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= cmd;
        amount   <= amt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_command(cmd, amt);
        words_sent++;
    endtask

    // Stop offering and wait until every owed reading has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Walk the corners from the reset state: idle ticks, ignored amounts,
    // saturation by minutes, hours and carry, restart at the ceiling,
    // exact borrows and both kinds of underflow, spare codes.
    task automatic test_directed_corners();
        send_word(etcs_pkg::MODE_TICK, 15'd0);
        send_word(etcs_pkg::MODE_CLEAR, AMOUNT_MAX);
        send_word(etcs_pkg::MODE_START, 15'h5555);
        send_word(etcs_pkg::MODE_TICK, 15'h2AAA);
        send_word(etcs_pkg::MODE_ADD_MIN, 15'd0);
        send_word(etcs_pkg::MODE_ADD_MIN, AMOUNT_MAX);
        send_word(etcs_pkg::MODE_ADD_HRS, 15'd453);
        send_word(etcs_pkg::MODE_ADD_MIN, 15'd52);
        send_word(etcs_pkg::MODE_ADD_MIN, 15'd1);
        send_word(etcs_pkg::MODE_SUB_MIN, 15'd0);
        send_word(etcs_pkg::MODE_START, 15'd0);
        send_word(etcs_pkg::MODE_TICK, 15'd0);
        send_word(etcs_pkg::MODE_SUB_MIN, 15'd1);
        send_word(etcs_pkg::MODE_START, 15'd0);
        send_word(etcs_pkg::MODE_TICK, 15'd0);
        send_word(etcs_pkg::MODE_STOP, 15'd0);
        send_word(etcs_pkg::MODE_TICK, 15'd0);
        send_word(etcs_pkg::MODE_ADD_HRS, AMOUNT_MAX);
        send_word(etcs_pkg::MODE_SUB_HRS, 15'd999);
        send_word(etcs_pkg::MODE_SUB_HRS, 15'd1);
        send_word(etcs_pkg::MODE_SUB_MIN, AMOUNT_MAX);
        send_word(etcs_pkg::MODE_SET_MAX, 15'd0);
        send_word(etcs_pkg::MODE_SUB_HRS, 15'd0);
        send_word(MODE_SPARE_FIRST, AMOUNT_MAX);
        send_word(MODE_SPARE_LAST, 15'd0);
        send_word(etcs_pkg::MODE_CLEAR, 15'd0);
    endtask

    // Random traffic: single commands, tick bursts, and runs that set the clock to
    // the ceiling, take a drawn amount of minutes or hours off, restart it and tick it.
    task automatic test_random_mix(input int target);
        int stop_at;
        int pick;
        int burst;
        stop_at = words_sent + target;
        while (words_sent < stop_at)
        begin
            if ($urandom_range(11, 0) == 0)
                steady_flow = ($urandom_range(2, 0) == 0);
            pick = $urandom_range(99, 0);
            if (pick < 20)
            begin
                send_word(etcs_pkg::MODE_SET_MAX, draw_amount());
                send_word(pick < 12 ? etcs_pkg::MODE_SUB_MIN : etcs_pkg::MODE_SUB_HRS,
                    draw_amount());
                send_word(etcs_pkg::MODE_START, draw_amount());
                burst = $urandom_range(6, 1);
                repeat (burst) send_word(etcs_pkg::MODE_TICK, draw_amount());
            end
            else if (pick < 35)
            begin
                burst = $urandom_range(30, 5);
                repeat (burst) send_word(etcs_pkg::MODE_TICK, draw_amount());
            end
            else
                send_word(draw_mode(), draw_amount());
        end
    endtask

    // Hold the output off for a long stretch while words keep coming, so
    // the block fills and pushes back on its input.
    task automatic test_output_backpressure();
        drain_results();
        steady_flow = 1'b1;
        @(negedge clk);
        hold_request = LONG_HOLD;
        @(posedge clk);
        repeat (24) send_word(draw_mode(), draw_amount());
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Output side: stall at random, or for one long stretch on request
    // ------------------------------------------------------------------

    initial
    begin
        int wait_left;
        wait_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                wait_left    = hold_request;
                hold_request = 0;
            end
            else if (out_valid && !out_stall)
                wait_left = steady_flow ? 0 : $urandom_range(MAX_IDLE, 0);
            if (wait_left > 0)
            begin
                out_stall <= 1'b1;
                wait_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result check: compare each taken word with the oldest prediction
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        etcs_pkg::etcs_state_t seen;
        etcs_pkg::etcs_state_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            seen.run           = etcs_pkg::etcs_run_t'(run_state);
            seen.count.hours   = hours;
            seen.count.minutes = minutes;
            seen.count.seconds = seconds;
            seen.count.frames  = frames;
            if (pending_readings.size() == 0)
                log_error($sformatf("unexpected result %0d:%0d:%0d:%0d state %0d",
                    hours, minutes, seconds, frames, run_state));
            else
            begin
                want = pending_readings.pop_front();
                results_checked++;
                if (seen.count.hours !== want.count.hours
                    || seen.count.minutes !== want.count.minutes
                    || seen.count.seconds !== want.count.seconds
                    || seen.count.frames !== want.count.frames
                    || seen.run !== want.run)
                    log_error($sformatf({"result %0d: want %0d:%0d:%0d:%0d state %0d, ",
                        "got %0d:%0d:%0d:%0d state %0d"},
                        results_checked,
                        want.count.hours, want.count.minutes, want.count.seconds,
                        want.count.frames, want.run,
                        hours, minutes, seconds, frames, run_state));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if neither side moves a word for too long
    // ------------------------------------------------------------------

    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck = 0;
            else
                stuck++;
        end
        $display("Timeout: no word moved for %0d cycles", STUCK_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        clear_clock();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        drain_results();
        test_random_mix(300);
        test_output_backpressure();
        test_random_mix(400);

        // Let any stray result surface after the last owed one.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_readings.size() != 0)
            log_error($sformatf("%0d results never arrived", pending_readings.size()));

        $display("Covered %0d commands and checked %0d results across all modes,",
            words_sent, results_checked);
        $display("with %0d entries to the maximum, %0d underflow restarts, a long stall and drains",
            max_entries, underflow_restarts);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
